@@ hw/rtl/neighbor_capacity_admission_top_assert.svh @@
// Assertion macros for the neighbor capacity admission block.
// Used by neighbor_capacity_admission_top; no other dependencies.
`ifndef NEIGHBOR_CAPACITY_ADMISSION_TOP_ASSERT_SVH
`define NEIGHBOR_CAPACITY_ADMISSION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NCA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nca assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define NCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nca assertion failed: next-cycle implication");

`endif

@@ hw/rtl/nca_pkg.sv @@
// Shared types and constants for the neighbor capacity admission block.
// Used by nca_cell, neighbor_capacity_admission_top and the testbench; no dependencies.
package nca_pkg;

  localparam int MAX_NEIGHBORS = 4;

  localparam int ADDR_W    = 64;
  localparam int RATE_W    = 24;
  localparam int CAP_W     = 28;
  localparam int CNT_W     = $clog2(MAX_NEIGHBORS + 1);
  localparam int SUM_W     = RATE_W + $clog2(MAX_NEIGHBORS + 1);
  localparam int OWN_W     = RATE_W + $clog2(MAX_NEIGHBORS + 2);
  localparam int CALC_W    = OWN_W + 3;
  localparam int NUM_SAT   = 4;
  localparam int SAT_IDX_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam int CAP_NO_NEIGHBORS = 2559744;
  localparam int CAP_MIN          = -134217728;
  localparam int CAP_MAX          = 134217727;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_RATE_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_RATE_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_RATE_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_RATE_FOUR  = 3'd4;

  // Request kinds.
  localparam logic KIND_HEARTBEAT = 1'b0;
  localparam logic KIND_QUERY     = 1'b1;

  localparam logic [RATE_W-1:0] SAT_RATE_ONE_RST   = 24'd39268;
  localparam logic [RATE_W-1:0] SAT_RATE_TWO_RST   = 24'd38707;
  localparam logic [RATE_W-1:0] SAT_RATE_THREE_RST = 24'd39539;
  localparam logic [RATE_W-1:0] SAT_RATE_FOUR_RST  = 24'd28524;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] sender_address;
    logic [RATE_W-1:0] rate;
    logic [ADDR_W-1:0] downstream_address;
  } nca_in_t;

  typedef struct packed {
    logic signed [CAP_W-1:0] capacity;
    logic                    rejected;
    logic                    table_full;
  } nca_out_t;

  // Token that walks the row of table cells, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] sender;
    logic [RATE_W-1:0] rate;
    logic [ADDR_W-1:0] downstream;
    logic              hit;
    logic              added;
    logic [SUM_W-1:0]  total;
    logic [OWN_W-1:0]  own;
  } nca_tok_t;

endpackage

@@ hw/rtl/nca_cell.sv @@
// One neighbor table entry plus its stage of the update and summing pass.
// Depends on nca_pkg.
module nca_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [nca_pkg::CNT_W-1:0] cell_idx,
  input  logic [nca_pkg::CNT_W-1:0] count,
  input  logic [nca_pkg::ADDR_W-1:0] my_address,
  input  nca_pkg::nca_tok_t         tok_in,
  output nca_pkg::nca_tok_t         tok_out
);
  import nca_pkg::*;

  logic [ADDR_W-1:0] address_r;
  logic [RATE_W-1:0] rate_r;
  logic [ADDR_W-1:0] downstream_r;
  nca_tok_t          tok_r;
  nca_tok_t          tok_nxt;

  logic              occupied;
  logic              free_slot;
  logic              open_req;
  logic              hit_here;
  logic              add_here;
  logic              wr_en;
  logic              counted;
  logic [RATE_W-1:0] eff_rate;
  logic [ADDR_W-1:0] eff_downstream;

  // Entries fill from index zero, so the first unused slot sits at the count.
  assign occupied  = cell_idx < count;
  assign free_slot = cell_idx == count;
  assign open_req  = tok_in.vld && !tok_in.hit && !tok_in.added;
  assign hit_here  = open_req && occupied && (address_r == tok_in.sender);
  assign add_here  = open_req && free_slot;
  assign wr_en     = hit_here || add_here;
  assign counted   = occupied || add_here;

  assign eff_rate       = wr_en ? tok_in.rate : rate_r;
  assign eff_downstream = wr_en ? tok_in.downstream : downstream_r;

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.hit   = tok_in.hit || hit_here;
    tok_nxt.added = tok_in.added || add_here;
    if (tok_in.vld && counted) begin
      tok_nxt.total = tok_in.total + SUM_W'(eff_rate);
      if (eff_downstream == my_address) begin
        tok_nxt.own = tok_in.own + OWN_W'(eff_rate);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      address_r    <= tok_in.sender;
      rate_r       <= tok_in.rate;
      downstream_r <= tok_in.downstream;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ hw/rtl/neighbor_capacity_admission_top.sv @@
// Top level of the neighbor capacity admission block.
// Depends on nca_pkg, nca_cell and neighbor_capacity_admission_top_assert.svh.
//
// A heartbeat request walks a row of MAX_NEIGHBORS table cells, one cell per
// cycle, updating or appending its entry and summing rates on the way. The
// result strobe is registered after the launch register and one register in
// each cell, with the capacity stage registered straight into the result. busy
// drops with that strobe, so the next request can be accepted while it is high.
// A query request is answered in the cycle after acceptance from the stored
// capacity and leaves busy low, so another request may follow at once. out_valid
// is high for exactly one cycle per request and the receiver cannot stall it.
// Configuration writes must be made only while no request is in flight.
`include "neighbor_capacity_admission_top_assert.svh"

module neighbor_capacity_admission_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  nca_pkg::nca_in_t              in_item,
  output logic                          out_valid,
  output nca_pkg::nca_out_t             out_item,
  input  logic                          cfg_we,
  input  logic [nca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nca_pkg::CFG_W-1:0]     cfg_wdata
);
  import nca_pkg::*;

  localparam logic signed [CALC_W-1:0] CALC_MIN = CALC_W'(CAP_MIN);
  localparam logic signed [CALC_W-1:0] CALC_MAX = CALC_W'(CAP_MAX);

  logic [ADDR_W-1:0]       my_address_r;
  logic [RATE_W-1:0]       sat_rate_r [NUM_SAT];
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic signed [CAP_W-1:0] local_cap_r;
  logic signed [CAP_W-1:0] cap_nxt;
  logic                    busy_r;
  logic                    out_valid_r;
  nca_out_t                out_r;
  nca_tok_t                launch_r;
  nca_tok_t                tok_w [MAX_NEIGHBORS+1];
  nca_tok_t                tok_last;

  logic                    in_accept;
  logic                    hb_accept;
  logic                    q_accept;
  logic [RATE_W-1:0]       sat_sel;
  logic signed [CALC_W-1:0] diff;
  logic                    q_reject;

  assign in_accept = start && !busy_r;
  assign hb_accept = in_accept && (in_item.kind == KIND_HEARTBEAT);
  assign q_accept  = in_accept && (in_item.kind == KIND_QUERY);

  assign tok_w[0] = launch_r;

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    nca_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (CNT_W'(i)),
      .count      (count_r),
      .my_address (my_address_r),
      .tok_in     (tok_w[i]),
      .tok_out    (tok_w[i+1])
    );
  end

  assign tok_last = tok_w[MAX_NEIGHBORS];

  // Final stage: saturation rate for the new count minus both sums.
  always_comb begin
    count_nxt = count_r + CNT_W'(tok_last.added);
    sat_sel   = sat_rate_r[SAT_IDX_W'(count_nxt - CNT_W'(1))];
    diff      = $signed({{(CALC_W-RATE_W){1'b0}}, sat_sel})
              - $signed({{(CALC_W-SUM_W){1'b0}}, tok_last.total})
              - $signed({{(CALC_W-OWN_W){1'b0}}, tok_last.own});
    if (count_nxt == '0) begin
      cap_nxt = CAP_W'(CAP_NO_NEIGHBORS);
    end else if (diff < CALC_MIN) begin
      cap_nxt = CAP_W'(CAP_MIN);
    end else if (diff > CALC_MAX) begin
      cap_nxt = CAP_W'(CAP_MAX);
    end else begin
      cap_nxt = diff[CAP_W-1:0];
    end
  end

  // The unsigned requested rate is compared against the signed capacity.
  assign q_reject = $signed({1'b0, {(CAP_W-RATE_W){1'b0}}, in_item.rate})
                  > $signed({local_cap_r[CAP_W-1], local_cap_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_address_r  <= '0;
      sat_rate_r[0] <= SAT_RATE_ONE_RST;
      sat_rate_r[1] <= SAT_RATE_TWO_RST;
      sat_rate_r[2] <= SAT_RATE_THREE_RST;
      sat_rate_r[3] <= SAT_RATE_FOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MY_ADDRESS:     my_address_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_SAT_RATE_ONE:   sat_rate_r[0] <= cfg_wdata[RATE_W-1:0];
        CFG_SAT_RATE_TWO:   sat_rate_r[1] <= cfg_wdata[RATE_W-1:0];
        CFG_SAT_RATE_THREE: sat_rate_r[2] <= cfg_wdata[RATE_W-1:0];
        CFG_SAT_RATE_FOUR:  sat_rate_r[3] <= cfg_wdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      local_cap_r <= CAP_W'(CAP_NO_NEIGHBORS);
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      launch_r    <= '0;
    end else begin
      out_valid_r  <= 1'b0;
      launch_r.vld <= 1'b0;
      if (hb_accept) begin
        busy_r              <= 1'b1;
        launch_r.vld        <= 1'b1;
        launch_r.sender     <= in_item.sender_address;
        launch_r.rate       <= in_item.rate;
        launch_r.downstream <= in_item.downstream_address;
        launch_r.hit        <= 1'b0;
        launch_r.added      <= 1'b0;
        launch_r.total      <= '0;
        // The heartbeat's own rate seeds the own-traffic sum.
        launch_r.own        <= OWN_W'(in_item.rate);
      end
      if (q_accept) begin
        out_valid_r         <= 1'b1;
        out_r.capacity      <= local_cap_r;
        out_r.rejected      <= q_reject;
        out_r.table_full    <= 1'b0;
      end
      if (tok_last.vld) begin
        busy_r           <= 1'b0;
        count_r          <= count_nxt;
        local_cap_r      <= cap_nxt;
        out_valid_r      <= 1'b1;
        out_r.capacity   <= cap_nxt;
        out_r.rejected   <= 1'b0;
        out_r.table_full <= !tok_last.hit && !tok_last.added;
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `NCA_ASSERT_NEXT(a_hb_sets_busy, clk, rst_n, hb_accept, busy_r)
  `NCA_ASSERT_NEXT(a_pass_ends_in_result, clk, rst_n, tok_last.vld, out_valid_r && !busy_r)
  `NCA_ASSERT_NOW(a_full_only_on_full_table, clk, rst_n, out_valid_r && out_r.table_full,
                  count_r == CNT_W'(MAX_NEIGHBORS))
  `NCA_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_NEIGHBORS))
  `NCA_ASSERT_NOW(a_reject_not_full, clk, rst_n, out_valid_r && out_r.rejected,
                  !out_r.table_full)

endmodule

@@ sim/tb_neighbor_capacity_admission_top.sv @@
// Testbench for neighbor_capacity_admission_top: directed table, then random heartbeats
// and queries over several register settings, checked against an in-bench table model.
// Depends on nca_pkg and the neighbor_capacity_admission_top RTL only.
`timescale 1ns / 1ps

module tb_neighbor_capacity_admission_top;
  import nca_pkg::*;

  localparam int     CYCLE_LIMIT     = 500000;
  localparam int     NUM_PHASES      = 8;
  localparam int     ITEMS_PER_PHASE = 130;
  localparam int     REPORT_MAX      = 10;
  localparam longint RATE_TOP        = (longint'(1) << RATE_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_SAT_RATE_FOUR + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [ADDR_W-1:0] ADDR_AAAA = {16{4'hA}};
  localparam logic [ADDR_W-1:0] ADDR_5555 = {16{4'h5}};

  typedef enum logic [1:0] {ROW_REQ, ROW_REQ_KNOWN, ROW_CFG} row_act_t;

  typedef struct packed {
    row_act_t              act;
    nca_in_t               req;
    nca_out_t              want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  nca_in_t               in_item;
  logic                  out_valid;
  nca_out_t              out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  // Neighbor table and register copies used for prediction.
  logic [ADDR_W-1:0] tbl_addr [MAX_NEIGHBORS];
  logic [RATE_W-1:0] tbl_rate [MAX_NEIGHBORS];
  logic [ADDR_W-1:0] tbl_down [MAX_NEIGHBORS];
  int                tbl_count;
  longint            cap_now;
  logic [ADDR_W-1:0] node_addr;
  logic [RATE_W-1:0] sat_rate [NUM_SAT];

  nca_out_t  cap_expect_q[$];
  dir_row_t  dir_rows[$];
  int        n_bad = 0;
  int        cyc_count = 0;

  neighbor_capacity_admission_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("tb_neighbor_capacity_admission_top failed");
      $finish;
    end
  end

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == CFG_MY_ADDRESS) begin
      node_addr = data;
    end else if (idx inside {[CFG_SAT_RATE_ONE:CFG_SAT_RATE_FOUR]}) begin
      sat_rate[SAT_IDX_W'(idx - CFG_SAT_RATE_ONE)] = data[RATE_W-1:0];
    end
  endfunction

  // Updates the neighbor table for a heartbeat and returns the capacity
  // response the block should give for this request.
  function automatic nca_out_t step_neighbor_table(nca_in_t req);
    nca_out_t res;
    int       hit;
    int       i;
    longint   sum_all;
    longint   own;
    longint   diff;
    res = '0;
    if (req.kind == KIND_HEARTBEAT) begin
      hit = -1;
      for (i = 0; i < tbl_count; i++) begin
        if (hit < 0 && tbl_addr[i] == req.sender_address) hit = i;
      end
      if (hit >= 0) begin
        tbl_rate[hit] = req.rate;
        tbl_down[hit] = req.downstream_address;
      end else if (tbl_count < MAX_NEIGHBORS) begin
        tbl_addr[tbl_count] = req.sender_address;
        tbl_rate[tbl_count] = req.rate;
        tbl_down[tbl_count] = req.downstream_address;
        tbl_count++;
      end else begin
        res.table_full = 1'b1;
      end
      // A dropped heartbeat still counts its own rate in the recompute.
      sum_all = 0;
      own = longint'(req.rate);
      for (i = 0; i < tbl_count; i++) begin
        sum_all += longint'(tbl_rate[i]);
        if (tbl_down[i] == node_addr) own += longint'(tbl_rate[i]);
      end
      diff = longint'(sat_rate[tbl_count - 1]) - sum_all - own;
      if (diff < CAP_MIN) diff = CAP_MIN;
      if (diff > CAP_MAX) diff = CAP_MAX;
      cap_now = diff;
    end else begin
      // The rate is unsigned, so a negative capacity rejects every request.
      res.rejected = (longint'(req.rate) > cap_now);
    end
    res.capacity = cap_now[CAP_W-1:0];
    return res;
  endfunction

  function automatic int pick_gap(bit burst);
    int sel;
    if (burst) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic nca_in_t mk_req(logic kind, logic [ADDR_W-1:0] sender,
                                     logic [RATE_W-1:0] rate, logic [ADDR_W-1:0] down);
    nca_in_t r;
    r.kind = kind;
    r.sender_address = sender;
    r.rate = rate;
    r.downstream_address = down;
    return r;
  endfunction

  function automatic void add_req(logic kind, logic [ADDR_W-1:0] sender,
                                  logic [RATE_W-1:0] rate, logic [ADDR_W-1:0] down);
    dir_row_t row;
    row = '0;
    row.act = ROW_REQ;
    row.req = mk_req(kind, sender, rate, down);
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void add_known(logic kind, logic [ADDR_W-1:0] sender,
                                    logic [RATE_W-1:0] rate, logic [ADDR_W-1:0] down,
                                    int cap, logic rej, logic full);
    dir_row_t row;
    row = '0;
    row.act = ROW_REQ_KNOWN;
    row.req = mk_req(kind, sender, rate, down);
    row.want.capacity = cap[CAP_W-1:0];
    row.want.rejected = rej;
    row.want.table_full = full;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.act = ROW_CFG;
    row.idx = idx;
    row.data = data;
    dir_rows = {dir_rows, row};
  endfunction

  task automatic rest(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Holds start low until every response has come back, then writes one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    start <= 1'b0;
    while (cap_expect_q.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_cfg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_req(input nca_in_t req, input bit known, input nca_out_t want);
    nca_out_t pred;
    @(negedge clk);
    start <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = step_neighbor_table(req);
    if (known) pred = want;
    cap_expect_q = {cap_expect_q, pred};
  endtask

  always @(posedge clk) begin
    nca_out_t want;
    if (rst_n && out_valid) begin
      if (cap_expect_q.size() == 0) begin
        n_bad++;
        if (n_bad <= REPORT_MAX)
          $display("unexpected response: capacity %0d rejected %0b table_full %0b",
                   $signed(out_item.capacity), out_item.rejected, out_item.table_full);
      end else begin
        want = cap_expect_q.pop_front();
        if (out_item.capacity !== want.capacity || out_item.rejected !== want.rejected ||
            out_item.table_full !== want.table_full) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("mismatch: expected capacity %0d rejected %0b table_full %0b, got %0d %0b %0b",
                     $signed(want.capacity), want.rejected, want.table_full,
                     $signed(out_item.capacity), out_item.rejected, out_item.table_full);
        end
      end
    end
  end

  initial begin
    nca_in_t            req;
    logic [RATE_W-1:0]  sat;
    logic [ADDR_W-1:0]  my;
    longint             v;
    int                 ph;
    int                 n;
    int                 j;
    int                 sel;
    bit                 burst;

    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tbl_count = 0;
    cap_now = CAP_NO_NEIGHBORS;
    node_addr = '0;
    sat_rate[0] = SAT_RATE_ONE_RST;
    sat_rate[1] = SAT_RATE_TWO_RST;
    sat_rate[2] = SAT_RATE_THREE_RST;
    sat_rate[3] = SAT_RATE_FOUR_RST;

    // Empty table, reset registers, then fill the table one neighbor at a time
    // while moving the first three saturation rates to an extreme.
    add_known(KIND_QUERY, '0, 24'd0, '0, CAP_NO_NEIGHBORS, 1'b0, 1'b0);
    add_known(KIND_QUERY, ADDR_ONES, 24'd2559744, ADDR_ONES, CAP_NO_NEIGHBORS, 1'b0, 1'b0);
    add_known(KIND_QUERY, ADDR_AAAA, '1, ADDR_5555, CAP_NO_NEIGHBORS, 1'b1, 1'b0);
    add_known(KIND_HEARTBEAT, '0, 24'd0, '0, 39268, 1'b0, 1'b0);
    add_cfg(CFG_SAT_RATE_ONE, {{(CFG_W-RATE_W){1'b1}}, {RATE_W{1'b1}}});
    add_req(KIND_HEARTBEAT, '0, 24'd256, ADDR_5555);
    add_req(KIND_HEARTBEAT, ADDR_ONES, 24'd1000, ADDR_ONES);
    add_cfg(CFG_SAT_RATE_TWO, '0);
    add_req(KIND_HEARTBEAT, ADDR_ONES, 24'd1, '0);
    add_req(KIND_QUERY, ADDR_5555, 24'd0, ADDR_AAAA);
    add_cfg(CFG_MY_ADDRESS, ADDR_ONES);
    add_req(KIND_HEARTBEAT, ADDR_AAAA, 24'h123456, ADDR_ONES);
    add_cfg(CFG_SAT_RATE_THREE, {RATE_W{1'b1}});
    add_req(KIND_HEARTBEAT, ADDR_5555, '1, ADDR_ONES);
    add_req(KIND_HEARTBEAT, 64'h0123_4567_89AB_CDEF, 24'd5, '0);
    add_req(KIND_QUERY, '0, 24'd1, '0);
    add_req(KIND_HEARTBEAT, '0, '1, ADDR_ONES);
    add_req(KIND_HEARTBEAT, ADDR_ONES, '1, ADDR_ONES);
    add_req(KIND_HEARTBEAT, ADDR_AAAA, '1, ADDR_ONES);
    // Every entry at full rate and routed through this node: the result clips low.
    add_known(KIND_HEARTBEAT, 64'hFEDC_BA98_7654_3210, '1, '0, CAP_MIN, 1'b0, 1'b1);
    add_known(KIND_QUERY, '0, 24'd0, '0, CAP_MIN, 1'b1, 1'b0);
    add_cfg(CFG_UNUSED_LO, '1);
    add_cfg(CFG_UNUSED_HI, '1);
    add_req(KIND_QUERY, ADDR_ONES, '1, ADDR_ONES);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      case (dir_rows[k].act)
        ROW_CFG: begin
          write_reg(dir_rows[k].idx, dir_rows[k].data);
        end
        ROW_REQ_KNOWN: begin
          send_req(dir_rows[k].req, 1'b1, dir_rows[k].want);
        end
        default: begin
          send_req(dir_rows[k].req, 1'b0, '0);
        end
      endcase
      rest(pick_gap(1'b0));
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          sat = '1;
          my = tbl_addr[$urandom_range(0, tbl_count - 1)];
        end
        1: begin
          sat = '0;
          my = '0;
        end
        2: begin
          sat = RATE_W'($urandom_range(20000, 60000));
          my = {$urandom, $urandom};
        end
        default: begin
          sat = '0;
          my = '1;
        end
      endcase
      write_reg(CFG_MY_ADDRESS, my);
      for (j = 0; j < NUM_SAT; j++) begin
        if (ph % 4 == 3) begin
          case (j)
            0: sat = SAT_RATE_ONE_RST;
            1: sat = SAT_RATE_TWO_RST;
            2: sat = SAT_RATE_THREE_RST;
            default: sat = SAT_RATE_FOUR_RST;
          endcase
        end
        write_reg(CFG_SAT_RATE_ONE + j[CFG_IDX_W-1:0],
                  {{(CFG_W-RATE_W){1'b0}}, sat} | ({$urandom, $urandom} << RATE_W));
      end
      if (ph % 2 == 1)
        write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                  {$urandom, $urandom});

      burst = (ph % 3 == 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        req.kind = $urandom_range(0, 1) ? KIND_QUERY : KIND_HEARTBEAT;
        req.sender_address = {$urandom, $urandom};
        req.downstream_address = {$urandom, $urandom};
        req.rate = RATE_W'($urandom);
        if (req.kind == KIND_HEARTBEAT) begin
          // Mostly known neighbors, so entries get updated; the rest are dropped.
          if ($urandom_range(0, 3) != 0)
            req.sender_address = tbl_addr[$urandom_range(0, tbl_count - 1)];
          sel = $urandom_range(0, 9);
          if (sel < 4) req.downstream_address = node_addr;
          else if (sel < 6) req.downstream_address = tbl_addr[$urandom_range(0, tbl_count - 1)];
          sel = $urandom_range(0, 9);
          if (sel == 0) req.rate = '0;
          else if (sel == 1) req.rate = '1;
          else if (sel < 7) req.rate = RATE_W'($urandom_range(0, 4000));
          else if (sel < 9) req.rate = RATE_W'($urandom_range(0, 65535));
        end else begin
          sel = $urandom_range(0, 5);
          if (sel == 0) begin
            req.rate = '0;
          end else if (sel == 1) begin
            req.rate = '1;
          end else if (sel < 4) begin
            // Land on or next to the current capacity.
            v = cap_now + longint'($urandom_range(0, 2)) - 1;
            if (v < 0) v = 0;
            if (v > RATE_TOP) v = RATE_TOP;
            req.rate = v[RATE_W-1:0];
          end
        end
        send_req(req, 1'b0, '0);
        rest(pick_gap(burst));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (cap_expect_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (n_bad == 0) begin
      $display("tb_neighbor_capacity_admission_top passed");
    end else begin
      $display("tb_neighbor_capacity_admission_top failed");
    end
    $finish;
  end

endmodule
